>>> hw/rtl/dx_multiple_recursive_rng_core_assert.svh
// assertion macros for the dx mrg core
// used by modules that check their own control logic
`ifndef DX_MULTIPLE_RECURSIVE_RNG_CORE_ASSERT_SVH
`define DX_MULTIPLE_RECURSIVE_RNG_CORE_ASSERT_SVH

// a property that holds whenever reset is released
`define DX_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// an implication whose consequent is checked in the cycle after the antecedent
`define DX_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/dxmrg_pkg.sv
// types and constants shared by the dx mrg core
// no dependencies
`timescale 1ns / 1ps
package dxmrg_pkg;
  localparam int unsigned WordW = 31;
  localparam int unsigned OrderW = 11;
  localparam int unsigned CfgIdxW = 3;
  localparam logic [WordW-1:0] ZeroSeedSubst = 31'd11111;

  localparam logic [CfgIdxW-1:0] CfgOrder = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgModulus = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgMult = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgSeedMult = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgForm = 3'd4;

  typedef struct packed {
    logic [WordW-1:0] value;
  } out_t;

  typedef struct packed {
    logic             func;
    logic [WordW-1:0] seed_value;
  } in_t;

  // request to the modular reduction unit
  typedef struct packed {
    logic              start;
    logic [2*WordW:0]  num;
    logic [WordW-1:0]  modulus;
  } mod_req_t;
endpackage

>>> hw/rtl/dxmrg_if.sv
// valid/ready channel interface carrying one payload
// no package dependency; the payload type is a parameter
`timescale 1ns / 1ps
interface dxmrg_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/dx_multiple_recursive_rng_core.sv
// dx-k-s multiple recursive generator: one item in flight, ring held in a synchronous memory
// a step reads two ring words, runs one reduction in the bit-serial unit and writes the result back;
// seeding writes the seed and then runs one reduction per further ring word in the bit-serial unit.
// the next item is taken once the result register frees.
// reset clears control state, registers take their reset values; the ring is undefined until seeded.
`timescale 1ns / 1ps
module dx_multiple_recursive_rng_core #(
  parameter int unsigned MAX_ORDER = 1024
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [dxmrg_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [dxmrg_pkg::WordW-1:0]      cfg_data_i,
  dxmrg_if.sink                            in_if,
  dxmrg_if.source                          out_if
);
  import dxmrg_pkg::*;
  localparam int unsigned AddrW = $clog2(MAX_ORDER);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRd1 = 3'd1;
  localparam logic [2:0] StRd2 = 3'd2;
  localparam logic [2:0] StCalc = 3'd3;
  localparam logic [2:0] StWait = 3'd4;
  localparam logic [2:0] StOut = 3'd5;

  logic [OrderW-1:0] order_q;
  logic [WordW-1:0]  modulus_q, mult_q, seed_mult_q;
  logic              form_q;

  logic [WordW:0] ring_mem [MAX_ORDER];
  logic [AddrW-1:0] rd_addr, wr_addr;
  logic             wr_en;
  logic [WordW:0]   wr_data, rd_data_q;

  logic [2:0]       st_q, st_d;
  logic [AddrW-1:0] pos_q, pos_d, idx_q, idx_d;
  logic             seed_q, seed_d;
  logic [WordW:0]   x_q, x_d, prev_q, prev_d;
  logic             ovalid_q, ovalid_d;
  logic [WordW-1:0] oval_q, oval_d;
  mod_req_t         req;
  logic             mod_busy, mod_done;
  logic [WordW-1:0] mod_rem;

  logic [OrderW-1:0] k_eff;
  logic [WordW-1:0]  p_eff;
  logic [AddrW-1:0]  last_idx, next_pos;
  logic [AddrW:0]    pos_inc;
  logic [WordW:0]    sum_xy;
  logic [2*WordW:0]  prod;
  logic [WordW-1:0]  seed_w;

  always_comb begin
    if (order_q < OrderW'(2)) k_eff = OrderW'(2);
    else if ({21'd0, order_q} > 32'(MAX_ORDER)) k_eff = OrderW'(MAX_ORDER);
    else k_eff = order_q;
    p_eff = (modulus_q < WordW'(2)) ? WordW'(2) : modulus_q;
    last_idx = AddrW'(k_eff - 1'b1);
    pos_inc = {1'b0, pos_q} + 1'b1;
    next_pos = (32'(pos_inc) >= 32'(k_eff)) ? '0 : pos_inc[AddrW-1:0];
    seed_w = (in_if.data.seed_value == '0) ? ZeroSeedSubst : in_if.data.seed_value;
    sum_xy = x_q + rd_data_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= OrderW'(47);
      modulus_q <= 31'h7fffffff;
      mult_q <= 31'd1;
      seed_mult_q <= 31'd16807;
      form_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgOrder:    order_q <= cfg_data_i[OrderW-1:0];
        CfgModulus:  modulus_q <= cfg_data_i;
        CfgMult:     mult_q <= cfg_data_i;
        CfgSeedMult: seed_mult_q <= cfg_data_i;
        CfgForm:     form_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    st_d = st_q;
    pos_d = pos_q;
    idx_d = idx_q;
    seed_d = seed_q;
    x_d = x_q;
    prev_d = prev_q;
    ovalid_d = ovalid_q;
    oval_d = oval_q;
    rd_addr = next_pos;
    wr_en = 1'b0;
    wr_addr = idx_q;
    wr_data = {1'b0, mod_rem};
    req = '0;
    req.modulus = p_eff;
    prod = '0;
    if (out_if.ready) ovalid_d = 1'b0;
    unique case (st_q)
      StIdle: begin
        if (in_if.valid && !ovalid_q) begin
          if (in_if.data.func) begin
            seed_d = 1'b1;
            wr_en = 1'b1;
            wr_addr = '0;
            wr_data = {1'b0, seed_w};
            prev_d = {1'b0, seed_w};
            idx_d = AddrW'(1);
            st_d = StCalc;
          end else begin
            seed_d = 1'b0;
            idx_d = next_pos;
            st_d = StRd1;
          end
        end
      end
      StRd1: begin
        x_d = rd_data_q;
        rd_addr = pos_q;
        st_d = StRd2;
      end
      StRd2: begin
        rd_addr = pos_q;
        st_d = StCalc;
      end
      StCalc: begin
        if (seed_q) begin
          prod = {32'd0, seed_mult_q} * {32'd0, prev_q[WordW-1:0]};
          if (prev_q[WordW]) prod = prod + {1'b0, seed_mult_q, 31'd0};
        end else if (form_q) begin
          prod = {32'd0, mult_q} * {31'd0, sum_xy};
        end else begin
          prod = {32'd0, mult_q} * {31'd0, x_q} + {31'd0, rd_data_q};
        end
        req.start = 1'b1;
        req.num = prod;
        st_d = StWait;
      end
      StWait: begin
        if (mod_done) begin
          wr_en = 1'b1;
          prev_d = {1'b0, mod_rem};
          if (seed_q && idx_q != last_idx) begin
            idx_d = idx_q + 1'b1;
            st_d = StCalc;
          end else begin
            pos_d = idx_q;
            st_d = StOut;
          end
        end
      end
      StOut: begin
        ovalid_d = 1'b1;
        oval_d = prev_q[WordW-1:0];
        st_d = StIdle;
      end
      default: st_d = StIdle;
    endcase
    if (st_q == StIdle && in_if.valid && !ovalid_q && in_if.data.func && last_idx == '0) begin
      st_d = StOut;
    end
  end

  assign in_if.ready = (st_q == StIdle) && !ovalid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) ring_mem[wr_addr] <= wr_data;
    rd_data_q <= ring_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      pos_q <= '0;
      ovalid_q <= 1'b0;
      seed_q <= 1'b0;
      idx_q <= '0;
    end else begin
      st_q <= st_d;
      pos_q <= pos_d;
      ovalid_q <= ovalid_d;
      seed_q <= seed_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    prev_q <= prev_d;
    oval_q <= oval_d;
  end

  dxmrg_mod u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .busy_o (mod_busy),
    .done_o (mod_done),
    .rem_o  (mod_rem)
  );

  assign out_if.valid = ovalid_q;
  assign out_if.data.value = oval_q;

  `include "dx_multiple_recursive_rng_core_assert.svh"
  `DX_ASSERT(a_no_take_busy, !(in_if.valid && in_if.ready && mod_busy), "item taken while busy")
  `DX_ASSERT(a_wait_busy, !(st_q == StWait && !mod_busy && !mod_done), "reduction lost")
  `DX_ASSERT_NEXT(a_out_after, st_q == StOut, out_if.valid, "result not shown")
endmodule

>>> hw/rtl/dxmrg_mod.sv
// restoring modular reduction, one quotient bit per cycle
// depends on dxmrg_pkg
`timescale 1ns / 1ps
module dxmrg_mod (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  dxmrg_pkg::mod_req_t    req_i,
  output logic                   busy_o,
  output logic                   done_o,
  output logic [dxmrg_pkg::WordW-1:0] rem_o
);
  import dxmrg_pkg::*;
  localparam int unsigned NumW = 2 * WordW + 1;
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0]  num_q, num_d;
  logic [WordW:0]   rem_q, rem_d;
  logic [WordW-1:0] mod_q, mod_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [WordW+1:0] shifted, diff;

  always_comb begin
    num_d = num_q;
    rem_d = rem_q;
    mod_d = mod_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    shifted = {rem_q, num_q[NumW-1]};
    diff = shifted - {2'b00, mod_q};
    if (req_i.start) begin
      num_d = req_i.num;
      rem_d = '0;
      mod_d = req_i.modulus;
      cnt_d = CntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[NumW-2:0], 1'b0};
      rem_d = diff[WordW+1] ? shifted[WordW:0] : diff[WordW:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    mod_q <= mod_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign rem_o = rem_q[WordW-1:0];
endmodule
